// ===== rtl/rgbhsv_pkg.sv =====
`default_nettype none

package rgbhsv_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned HueW   = 15;
  localparam int unsigned SatW   = 9;
  // quotient bits produced by each long divider, and bits retired per stage
  localparam int unsigned QuoW   = 12;
  localparam int unsigned QPerSt = 2;
  localparam int unsigned DivSt  = QuoW / QPerSt;

  localparam logic [HueW-1:0] HueBaseGreen = 15'd7680;
  localparam logic [HueW-1:0] HueBaseBlue  = 15'd15360;
  localparam logic [HueW-1:0] HueFull      = 15'd23040;
  localparam logic [SatW-1:0] SatOne       = 9'd256;

  typedef enum logic [1:0] {
    SecRed   = 2'd0,
    SecGreen = 2'd1,
    SecBlue  = 2'd2
  } sector_e;

  // after max/min search
  typedef struct packed {
    logic [ChanW-1:0]  hi;
    logic [ChanW-1:0]  delta;
    logic signed [ChanW:0] diff;
    sector_e           sector;
    logic              undef;
  } front_t;

  // one slot of the two parallel long dividers
  typedef struct packed {
    logic [ChanW-1:0] hi;
    logic [ChanW-1:0] delta;
    sector_e          sector;
    logic             neg;
    logic             undef;
    logic [ChanW-1:0] rem_h;
    logic [QuoW-1:0]  nlo_h;
    logic [QuoW-1:0]  q_h;
    logic [ChanW-1:0] rem_s;
    logic [QuoW-1:0]  nlo_s;
    logic [QuoW-1:0]  q_s;
  } div_t;

endpackage

`default_nettype wire

// ===== rtl/rgb_to_hsv_convert.sv =====
`default_nettype none

// rgb to hsv pixel converter. each transfer on the input channel carries one
// 8-bit rgb pixel; each transfer on the output channel carries its hsv result:
// brightness is the largest channel, saturation is floor(delta*256/max) with
// 256 meaning one, hue is in 1/64 degree (0..23039) built from a sector base
// of 0, 7680 or 15360 plus 3840*difference/delta truncated toward zero, and
// gray pixels (delta of zero) give hue 0, saturation 0 and hue_undefined set.
// ties for the maximum go to red, then green. one pixel is taken every clock
// cycle while the output is not stalled, and each result passes through, in
// order, one stage for the max/min search, one for the hue numerator, six
// for the two 12-bit long dividers (hue and saturation, two quotient bits per
// stage) and one output register. a stall at the output backs up stage by
// stage, and empty stages keep filling while later ones wait.
module rgb_to_hsv_convert
  import rgbhsv_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [ChanW-1:0] red_i,
  input  wire logic [ChanW-1:0] green_i,
  input  wire logic [ChanW-1:0] blue_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [HueW-1:0]       hue_o,
  output logic [SatW-1:0]       saturation_o,
  output logic [ChanW-1:0]      brightness_o,
  output logic                  hue_undefined_o
);

  // two restoring division steps on both dividers
  function automatic div_t div_step2(div_t s);
    div_t            r;
    logic [ChanW:0]  t;
    r = s;
    for (int i = 0; i < QPerSt; i++) begin
      // hue divider: divisor is delta
      t = {r.rem_h, r.nlo_h[QuoW-1]};
      if (t >= {1'b0, r.delta}) begin
        t = t - {1'b0, r.delta};
        r.q_h = {r.q_h[QuoW-2:0], 1'b1};
      end else begin
        r.q_h = {r.q_h[QuoW-2:0], 1'b0};
      end
      r.rem_h = t[ChanW-1:0];
      r.nlo_h = {r.nlo_h[QuoW-2:0], 1'b0};
      // saturation divider: divisor is max
      t = {r.rem_s, r.nlo_s[QuoW-1]};
      if (t >= {1'b0, r.hi}) begin
        t = t - {1'b0, r.hi};
        r.q_s = {r.q_s[QuoW-2:0], 1'b1};
      end else begin
        r.q_s = {r.q_s[QuoW-2:0], 1'b0};
      end
      r.rem_s = t[ChanW-1:0];
      r.nlo_s = {r.nlo_s[QuoW-2:0], 1'b0};
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stall chain: a stage loads when it is empty or its successor loads
  // ---------------------------------------------------------------------------
  logic              out_en;
  logic [DivSt:0]    div_en;
  logic              front_en;

  logic              front_v_q;
  front_t            front_q, front_d;
  logic [DivSt:0]    div_v_q;
  div_t              div_q [DivSt+1];
  div_t              div_d [DivSt+1];

  logic              out_v_q;
  logic [HueW-1:0]   hue_q, hue_d;
  logic [SatW-1:0]   sat_q, sat_d;
  logic [ChanW-1:0]  bright_q;
  logic              undef_q;

  assign out_en = !out_v_q || out_ready_i;

  always_comb begin
    div_en[DivSt] = !div_v_q[DivSt] || out_en;
    for (int k = DivSt - 1; k >= 0; k--) begin
      div_en[k] = !div_v_q[k] || div_en[k+1];
    end
  end

  assign front_en   = !front_v_q || div_en[0];
  assign in_ready_o = front_en;

  // ---------------------------------------------------------------------------
  // stage 1: max, min, delta, sector and signed channel difference
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [ChanW-1:0] hi;
    logic [ChanW-1:0] lo;
    hi = (red_i > green_i) ? red_i : green_i;
    lo = (red_i < green_i) ? red_i : green_i;
    hi = (hi > blue_i) ? hi : blue_i;
    lo = (lo < blue_i) ? lo : blue_i;
    front_d.hi    = hi;
    front_d.delta = hi - lo;
    front_d.undef = (hi == lo);
    if (red_i == hi) begin
      front_d.sector = SecRed;
      front_d.diff   = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
    end else if (green_i == hi) begin
      front_d.sector = SecGreen;
      front_d.diff   = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
    end else begin
      front_d.sector = SecBlue;
      front_d.diff   = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_v_q <= 1'b0;
    end else if (front_en) begin
      front_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (front_en) begin
      front_q <= front_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: hue numerator 3840*|diff|, saturation numerator delta*256,
  // both split into the starting remainder and the bits still to shift in
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [ChanW:0]        dneg;
    logic [ChanW-1:0]      mag;
    logic [ChanW+QuoW-1:0] num_h;
    dneg  = -front_q.diff;
    mag   = front_q.diff[ChanW] ? dneg[ChanW-1:0] : front_q.diff[ChanW-1:0];
    // 3840 = 4096 - 256
    num_h = {mag, 12'b0} - {4'b0, mag, 8'b0};
    div_d[0].hi     = front_q.hi;
    div_d[0].delta  = front_q.delta;
    div_d[0].sector = front_q.sector;
    div_d[0].neg    = front_q.diff[ChanW];
    div_d[0].undef  = front_q.undef;
    div_d[0].rem_h  = num_h[ChanW+QuoW-1:QuoW];
    div_d[0].nlo_h  = num_h[QuoW-1:0];
    div_d[0].q_h    = '0;
    div_d[0].rem_s  = {4'b0, front_q.delta[ChanW-1:4]};
    div_d[0].nlo_s  = {front_q.delta[3:0], 8'b0};
    div_d[0].q_s    = '0;
  end

  // ---------------------------------------------------------------------------
  // divider stages: two quotient bits per stage on each divider
  // ---------------------------------------------------------------------------
  for (genvar k = 1; k <= DivSt; k++) begin : g_div
    assign div_d[k] = div_step2(div_q[k-1]);
  end

  for (genvar k = 0; k <= DivSt; k++) begin : g_div_reg
    logic prev_v;
    if (k == 0) begin : g_first
      assign prev_v = front_v_q;
    end else begin : g_rest
      assign prev_v = div_v_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_v_q[k] <= 1'b0;
      end else if (div_en[k]) begin
        div_v_q[k] <= prev_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (div_en[k]) begin
        div_q[k] <= div_d[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output stage: sign of the quotient, sector base, wrap of negative hue
  // ---------------------------------------------------------------------------
  always_comb begin
    logic signed [HueW:0] qs;
    logic signed [HueW:0] hs;
    logic [HueW-1:0]      base;
    unique case (div_q[DivSt].sector)
      SecRed:   base = '0;
      SecGreen: base = HueBaseGreen;
      SecBlue:  base = HueBaseBlue;
      default:  base = '0;
    endcase
    qs = $signed({4'b0, div_q[DivSt].q_h});
    hs = $signed({1'b0, base}) + (div_q[DivSt].neg ? -qs : qs);
    if (hs[HueW]) begin
      hs = hs + $signed({1'b0, HueFull});
    end
    if (div_q[DivSt].undef) begin
      hue_d = '0;
      sat_d = '0;
    end else begin
      hue_d = hs[HueW-1:0];
      sat_d = div_q[DivSt].q_s[SatW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_en) begin
      out_v_q <= div_v_q[DivSt];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      hue_q    <= hue_d;
      sat_q    <= sat_d;
      bright_q <= div_q[DivSt].hi;
      undef_q  <= div_q[DivSt].undef;
    end
  end

  assign out_valid_o     = out_v_q;
  assign hue_o           = hue_q;
  assign saturation_o    = sat_q;
  assign brightness_o    = bright_q;
  assign hue_undefined_o = undef_q;

endmodule

`default_nettype wire

// ===== rtl/rgbhsv_checker.sv =====
`default_nettype none

module rgbhsv_checker
  import rgbhsv_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_ready_o,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic [HueW-1:0]  hue_o,
  input wire logic [SatW-1:0]  saturation_o,
  input wire logic [ChanW-1:0] brightness_o,
  input wire logic             hue_undefined_o
);

  // a stalled result holds still
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hue_o)
      && $stable(saturation_o) && $stable(brightness_o) && $stable(hue_undefined_o))
    else $error("stalled result changed");

  // gray pixel forces hue and saturation to zero
  a_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hue_undefined_o |-> hue_o == '0 && saturation_o == '0)
    else $error("gray pixel with nonzero hue or saturation");

  // results stay inside their ranges
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hue_o < HueFull && saturation_o <= SatOne)
    else $error("hue or saturation out of range");

  // black is always gray
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && brightness_o == '0 |-> hue_undefined_o)
    else $error("black pixel without hue_undefined");

  // with the output empty nothing can hold the input back
  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked while output empty");

endmodule

bind rgb_to_hsv_convert rgbhsv_checker u_rgbhsv_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .hue_o           (hue_o),
  .saturation_o    (saturation_o),
  .brightness_o    (brightness_o),
  .hue_undefined_o (hue_undefined_o)
);

`default_nettype wire

// ===== dv/rgb_to_hsv_convert_tb.sv =====
`default_nettype none

module rgb_to_hsv_convert_tb;
  import rgbhsv_pkg::*;

  // hue of one full sector, 60 degrees in 1/64 degree
  localparam int HueSector = 3840;
  localparam int RandPixels = 950;
  // random pixel indexes with no idling on either side
  localparam int BurstFirst = 400;
  localparam int BurstLast = 549;
  // random pixel index where the sender holds off until the pipe drains
  localparam int DrainAt = 700;
  localparam int SettleCycles = 16;

  // one converted pixel as it leaves the block
  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic [SatW-1:0]  sat;
    logic [ChanW-1:0] bright;
    logic             undef;
  } hsv_t;

  // one row of the directed table; the result only counts when typed is set
  typedef struct packed {
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
    logic             typed;
    logic [HueW-1:0]  hue;
    logic [SatW-1:0]  sat;
    logic [ChanW-1:0] bright;
    logic             undef;
  } pixel_row_t;

  localparam int NumRows = 24;
  localparam pixel_row_t PixelTable [NumRows] = '{
    // gray pixels: black, white, mid gray
    '{8'd0,   8'd0,   8'd0,   1'b1, 15'd0,     9'd0,   8'd0,   1'b1},
    '{8'd255, 8'd255, 8'd255, 1'b1, 15'd0,     9'd0,   8'd255, 1'b1},
    '{8'd128, 8'd128, 8'd128, 1'b1, 15'd0,     9'd0,   8'd128, 1'b1},
    // pure primaries at full scale
    '{8'd255, 8'd0,   8'd0,   1'b1, 15'd0,     9'd256, 8'd255, 1'b0},
    '{8'd0,   8'd255, 8'd0,   1'b1, 15'd7680,  9'd256, 8'd255, 1'b0},
    '{8'd0,   8'd0,   8'd255, 1'b1, 15'd15360, 9'd256, 8'd255, 1'b0},
    // two-way ties for the max: yellow, cyan, magenta (magenta wraps)
    '{8'd255, 8'd255, 8'd0,   1'b1, 15'd3840,  9'd256, 8'd255, 1'b0},
    '{8'd0,   8'd255, 8'd255, 1'b1, 15'd11520, 9'd256, 8'd255, 1'b0},
    '{8'd255, 8'd0,   8'd255, 1'b1, 15'd19200, 9'd256, 8'd255, 1'b0},
    // smallest nonzero delta at the bottom and top of the range
    '{8'd1,   8'd0,   8'd0,   1'b1, 15'd0,     9'd256, 8'd1,   1'b0},
    '{8'd255, 8'd254, 8'd254, 1'b1, 15'd0,     9'd1,   8'd255, 1'b0},
    // negative hue just under a full circle
    '{8'd255, 8'd0,   8'd1,   1'b0, 15'd0,     9'd0,   8'd0,   1'b0},
    // each sector with positive and negative difference, inexact quotient
    '{8'd200, 8'd0,   8'd7,   1'b0, 15'd0,     9'd0,   8'd0,   1'b0},
    '{8'd200, 8'd7,   8'd0,   1'b0, 15'd0,     9'd0,   8'd0,   1'b0},
    '{8'd7,   8'd200, 8'd0,   1'b0, 15'd0,     9'd0,   8'd0,   1'b0},
    '{8'd0,   8'd200, 8'd7,   1'b0, 15'd0,     9'd0,   8'd0,   1'b0},
    '{8'd0,   8'd7,   8'd200, 1'b0, 15'd0,     9'd0,   8'd0,   1'b0},
    '{8'd7,   8'd0,   8'd200, 1'b0, 15'd0,     9'd0,   8'd0,   1'b0},
    '{8'd170, 8'd85,  8'd255, 1'b0, 15'd0,     9'd0,   8'd0,   1'b0},
    '{8'd1,   8'd2,   8'd3,   1'b0, 15'd0,     9'd0,   8'd0,   1'b0},
    '{8'd254, 8'd1,   8'd128, 1'b0, 15'd0,     9'd0,   8'd0,   1'b0},
    // partial ties: green over blue, red over blue
    '{8'd85,  8'd170, 8'd170, 1'b0, 15'd0,     9'd0,   8'd0,   1'b0},
    '{8'd3,   8'd0,   8'd3,   1'b0, 15'd0,     9'd0,   8'd0,   1'b0},
    '{8'd2,   8'd1,   8'd1,   1'b0, 15'd0,     9'd0,   8'd0,   1'b0}
  };

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [ChanW-1:0] red_i = '0;
  logic [ChanW-1:0] green_i = '0;
  logic [ChanW-1:0] blue_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [HueW-1:0]  hue_o;
  logic [SatW-1:0]  saturation_o;
  logic [ChanW-1:0] brightness_o;
  logic             hue_undefined_o;

  // results still owed by the block, oldest first
  hsv_t        pending_hsv_q [$];
  // result owed for the pixel currently offered on the input
  hsv_t        offered_hsv = '0;
  // set while neither side is allowed to idle
  bit          burst = 1'b0;
  int unsigned n_errors = 0;

  rgb_to_hsv_convert u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .red_i           (red_i),
    .green_i         (green_i),
    .blue_i          (blue_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hue_o           (hue_o),
    .saturation_o    (saturation_o),
    .brightness_o    (brightness_o),
    .hue_undefined_o (hue_undefined_o)
  );

  always #4 clk_i = ~clk_i;

  // hsv of one pixel: max is brightness, first channel equal to max picks the sector
  function automatic hsv_t hsv_of_pixel(input logic [ChanW-1:0] r, g, b);
    int      ri, gi, bi;
    int      hi, lo, delta, h;
    sector_e sec;
    hsv_t    res;
    ri = int'(r);
    gi = int'(g);
    bi = int'(b);
    hi = (ri > gi) ? ri : gi;
    hi = (hi > bi) ? hi : bi;
    lo = (ri < gi) ? ri : gi;
    lo = (lo < bi) ? lo : bi;
    delta = hi - lo;
    res = '0;
    res.bright = hi[ChanW-1:0];
    if (delta == 0) begin
      // gray: hue and saturation stay zero
      res.undef = 1'b1;
    end else begin
      res.sat = SatW'((delta * int'(SatOne)) / hi);
      if (ri == hi) sec = SecRed;
      else if (gi == hi) sec = SecGreen;
      else sec = SecBlue;
      // int division truncates toward zero, as the block must
      case (sec)
        SecRed:   h = (HueSector * (gi - bi)) / delta;
        SecGreen: h = int'(HueBaseGreen) + (HueSector * (bi - ri)) / delta;
        default:  h = int'(HueBaseBlue) + (HueSector * (ri - gi)) / delta;
      endcase
      if (h < 0) h += int'(HueFull);
      res.hue = HueW'(h);
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      n_errors++;
    end
  endtask

  // output side first, then the input transfer; both see pre-edge values
  always @(posedge clk_i) begin
    hsv_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (pending_hsv_q.size() == 0) begin
        $error("result transfer with no pixel outstanding");
        n_errors++;
      end else begin
        want = pending_hsv_q.pop_front();
        check_field("hue", 32'(want.hue), 32'(hue_o));
        check_field("saturation", 32'(want.sat), 32'(saturation_o));
        check_field("brightness", 32'(want.bright), 32'(brightness_o));
        check_field("hue_undefined", 32'(want.undef), 32'(hue_undefined_o));
      end
    end
    if (rst_ni && in_valid_i && in_ready_o === 1'b1) pending_hsv_q.push_back(offered_hsv);
  end

  // receiver stalls at random about 28 percent of the time, except during a burst
  always @(negedge clk_i) begin
    out_ready_i <= burst || ($urandom_range(99) >= 28);
  end

  // offer one pixel, idling first at random, and return at its transfer edge
  task automatic send_pixel(input logic [ChanW-1:0] r, g, b, input hsv_t want);
    @(negedge clk_i);
    while (!burst && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_i <= r;
    green_i <= g;
    blue_i <= b;
    offered_hsv = want;
    forever begin
      @(posedge clk_i);
      if (in_ready_o === 1'b1) break;
    end
  endtask

  // hold the input off until every owed result has come back
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_hsv_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [ChanW-1:0] px [3];
    hsv_t             want;
    int unsigned      sel;
    int               v, t;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (PixelTable[i]) begin
      if (PixelTable[i].typed) begin
        want = '{PixelTable[i].hue, PixelTable[i].sat, PixelTable[i].bright,
                 PixelTable[i].undef};
      end else begin
        want = hsv_of_pixel(PixelTable[i].r, PixelTable[i].g, PixelTable[i].b);
      end
      send_pixel(PixelTable[i].r, PixelTable[i].g, PixelTable[i].b, want);
    end
    drain_results();

    // random pixels: gray, near gray, full-scale extremes, and uniform
    for (int i = 0; i < RandPixels; i++) begin
      burst = (i >= BurstFirst && i <= BurstLast);
      if (i == DrainAt) drain_results();
      sel = $urandom_range(99);
      v = $urandom_range(255);
      foreach (px[c]) begin
        if (sel < 10) begin
          px[c] = v[ChanW-1:0];
        end else if (sel < 25) begin
          t = v + int'($urandom_range(6)) - 3;
          if (t < 0) t = 0;
          if (t > 255) t = 255;
          px[c] = t[ChanW-1:0];
        end else if (sel < 40) begin
          case ($urandom_range(2))
            0:       px[c] = '0;
            1:       px[c] = '1;
            default: px[c] = ChanW'($urandom_range(255));
          endcase
        end else begin
          px[c] = ChanW'($urandom_range(255));
        end
      end
      send_pixel(px[0], px[1], px[2], hsv_of_pixel(px[0], px[1], px[2]));
    end
    burst = 1'b0;

    drain_results();
    // catch any stray result transfer after the last one owed
    repeat (SettleCycles) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
